[src/plt_pkg.sv]
// ----------------------------------------------------------------------------
// plt_pkg: shared types and constants of the peer link loss tracker
// Field widths, status codes, the peer table entry and the result word.
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int unsigned MAC_W    = 48;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned RSSI_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 6;

  localparam int unsigned MAX_PEERS_DEF = 8;

  localparam logic signed [RSSI_W-1:0] NEW_PEER_RSSI = -8'sd127;

  typedef enum logic [STATUS_W-1:0] {
    ST_KNOWN    = 2'd0,
    ST_ADDED    = 2'd1,
    ST_FULL     = 2'd2,
    ST_AUTHFAIL = 2'd3
  } status_e;

  typedef struct packed {
    logic [MAC_W-1:0]         mac;
    logic [SEQ_W-1:0]         last_seq;
    logic [SEQ_W-1:0]         lost;
    logic signed [RSSI_W-1:0] rssi;
  } peer_entry_t;

  typedef struct packed {
    status_e                  status;
    logic [INDEX_W-1:0]       entry_idx;
    logic [SEQ_W-1:0]         lost_packets;
    logic signed [RSSI_W-1:0] peer_rssi;
  } result_t;

endpackage

[src/plt_in_if.sv]
// ----------------------------------------------------------------------------
// plt_in_if: received packet channel
// Valid/ready channel that carries one received packet word.
// ----------------------------------------------------------------------------
interface plt_in_if;

  logic                                  valid;
  logic                                  ready;
  logic [plt_pkg::MAC_W-1:0]             src_mac;
  logic [plt_pkg::SEQ_W-1:0]             seq_num;
  logic signed [plt_pkg::RSSI_W-1:0]     rssi;
  logic                                  auth_ok;

  modport source (output valid, output src_mac, output seq_num, output rssi,
                  output auth_ok, input ready);
  modport sink   (input valid, input src_mac, input seq_num, input rssi,
                  input auth_ok, output ready);

endinterface

[src/plt_out_if.sv]
// ----------------------------------------------------------------------------
// plt_out_if: peer result channel
// Valid/ready channel that carries one peer status word.
// ----------------------------------------------------------------------------
interface plt_out_if;

  logic                                  valid;
  logic                                  ready;
  logic [plt_pkg::STATUS_W-1:0]          status;
  logic [plt_pkg::INDEX_W-1:0]           entry_idx;
  logic [plt_pkg::SEQ_W-1:0]             lost_packets;
  logic signed [plt_pkg::RSSI_W-1:0]     peer_rssi;

  modport source (output valid, output status, output entry_idx,
                  output lost_packets, output peer_rssi, input ready);
  modport sink   (input valid, input status, input entry_idx,
                  input lost_packets, input peer_rssi, output ready);

endinterface

[src/plt_ram.sv]
// ----------------------------------------------------------------------------
// plt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module plt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/plt_engine.sv]
// ----------------------------------------------------------------------------
// plt_engine: peer search and update sequencer
// Walks the peer memory one entry per cycle, then updates the matched entry or appends a new one.
// ----------------------------------------------------------------------------
module plt_engine #(
  parameter int unsigned MAX_PEERS = plt_pkg::MAX_PEERS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  plt_in_if.sink            pkt_i,
  input  logic              ground_mode_i,
  input  logic              res_free_i,
  output logic              res_valid_o,
  output plt_pkg::result_t  res_o
);

  localparam int unsigned IDX_W   = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_PEERS + 1);
  localparam int unsigned ENTRY_W = $bits(plt_pkg::peer_entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_GAP,
    S_UPDATE,
    S_EMIT
  } state_e;

  state_e                               state_q;
  logic [IDX_W-1:0]                     idx_q;
  logic [CNT_W-1:0]                     cnt_q;

  logic [plt_pkg::MAC_W-1:0]            mac_q;
  logic [plt_pkg::SEQ_W-1:0]            seq_q;
  logic signed [plt_pkg::RSSI_W-1:0]    rssi_q;
  plt_pkg::status_e                     status_q;
  logic [plt_pkg::SEQ_W-1:0]            last_q;
  logic [plt_pkg::SEQ_W-1:0]            lost_q;
  logic signed [plt_pkg::RSSI_W-1:0]    peer_rssi_q;
  logic                                 lt_q;
  logic [plt_pkg::SEQ_W-1:0]            gap_q;
  plt_pkg::result_t                     res_q;

  logic                                 accept;
  logic                                 hit;
  logic                                 last_idx;
  logic                                 rd_en;
  logic [IDX_W-1:0]                     rd_addr;
  logic [ENTRY_W-1:0]                   rd_data;
  plt_pkg::peer_entry_t                 rd_entry;
  logic                                 wr_en;
  plt_pkg::peer_entry_t                 wr_entry;
  logic [plt_pkg::SEQ_W-1:0]            lost_new;
  logic signed [plt_pkg::RSSI_W-1:0]    rssi_new;

  assign pkt_i.ready = (state_q == S_IDLE);
  assign accept      = pkt_i.valid && pkt_i.ready;

  assign rd_entry = plt_pkg::peer_entry_t'(rd_data);
  assign hit      = (rd_entry.mac == mac_q);
  assign last_idx = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state_q == S_IDLE) begin
      rd_en = accept;
    end else if (state_q == S_SEARCH) begin
      rd_en   = !hit && !last_idx;
      rd_addr = idx_q + IDX_W'(1);
    end
  end

  assign lost_new = lt_q ? (lost_q + gap_q) : '0;
  assign rssi_new = ground_mode_i ? rssi_q : peer_rssi_q;

  assign wr_en             = (state_q == S_UPDATE);
  assign wr_entry.mac      = mac_q;
  assign wr_entry.last_seq = seq_q;
  assign wr_entry.lost     = lost_new;
  assign wr_entry.rssi     = rssi_new;

  plt_ram #(
    .Width (ENTRY_W),
    .Depth (MAX_PEERS),
    .AddrW (IDX_W)
  ) u_peer_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx_q),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      mac_q       <= '0;
      seq_q       <= '0;
      rssi_q      <= '0;
      status_q    <= plt_pkg::ST_KNOWN;
      last_q      <= '0;
      lost_q      <= '0;
      peer_rssi_q <= '0;
      lt_q        <= 1'b0;
      gap_q       <= '0;
      res_q       <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            idx_q       <= '0;
            mac_q       <= pkt_i.src_mac;
            seq_q       <= pkt_i.seq_num;
            rssi_q      <= pkt_i.rssi;
            last_q      <= '0;
            lost_q      <= '0;
            peer_rssi_q <= plt_pkg::NEW_PEER_RSSI;
            status_q    <= pkt_i.auth_ok ? plt_pkg::ST_ADDED : plt_pkg::ST_AUTHFAIL;
            res_q       <= '{status: plt_pkg::ST_AUTHFAIL, entry_idx: '0,
                             lost_packets: '0, peer_rssi: '0};
            if (!pkt_i.auth_ok) begin
              state_q <= S_EMIT;
            end else if (cnt_q == '0) begin
              state_q <= S_GAP;
            end else begin
              state_q <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (hit) begin
            last_q      <= rd_entry.last_seq;
            lost_q      <= rd_entry.lost;
            peer_rssi_q <= rd_entry.rssi;
            status_q    <= plt_pkg::ST_KNOWN;
            state_q     <= S_GAP;
          end else if (last_idx) begin
            if (cnt_q == CNT_W'(MAX_PEERS)) begin
              status_q <= plt_pkg::ST_FULL;
              res_q    <= '{status: plt_pkg::ST_FULL, entry_idx: '0,
                            lost_packets: '0, peer_rssi: '0};
              state_q  <= S_EMIT;
            end else begin
              idx_q   <= cnt_q[IDX_W-1:0];
              state_q <= S_GAP;
            end
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        S_GAP: begin
          lt_q    <= (last_q < seq_q);
          gap_q   <= seq_q - last_q - plt_pkg::SEQ_W'(1);
          state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          if (status_q == plt_pkg::ST_ADDED) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          res_q   <= '{status: status_q,
                       entry_idx: plt_pkg::INDEX_W'(idx_q),
                       lost_packets: lost_new,
                       peer_rssi: rssi_new};
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (res_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = (state_q == S_EMIT);
  assign res_o       = res_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_PEERS))
    else $error("Peer count exceeds the table size.");

  a_write_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE) |->
      ((CNT_W'(idx_q) < cnt_q) ||
       ((status_q == plt_pkg::ST_ADDED) && (CNT_W'(idx_q) == cnt_q))))
    else $error("Peer memory write outside the filled part of the table.");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      ((cnt_q == ($past(cnt_q) + CNT_W'(1))) && ($past(state_q) == S_UPDATE)))
    else $error("Peer count changed other than by one append.");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EMIT) && (res_q.status == plt_pkg::ST_FULL)) |->
      (cnt_q == CNT_W'(MAX_PEERS)))
    else $error("Table full reported while the table has room.");

endmodule

[src/peer_link_loss_tracker.sv]
// ----------------------------------------------------------------------------
// peer_link_loss_tracker: per-peer link statistics for received packets
// Tracks RSSI and lost packet counts for up to MAX_PEERS peers by MAC.
// ----------------------------------------------------------------------------
// Packet words enter on pkt_i and one status word per packet leaves on res_o;
// both are valid/ready channels and a word moves when valid and ready are high.
// The user must write the ground_mode register through ground_mode_we_i only
// while idle; the block itself does not enforce this. One packet is processed
// at a time. An unauthenticated packet's word is emitted without a search. For
// an authenticated packet the entries below the peer count are searched, the
// sequence gap is computed and the entry is updated or appended before the
// word is emitted; a packet dropped because the table is full is emitted once
// the whole table is searched. The search reads the peer memory through its
// single read port one entry per cycle. pkt_i is ready again in the cycle
// after the result is handed to the output register, so with a free receiver
// a packet holds the block until its word can be taken from res_o.
// Reset empties the peer table and clears ground_mode; no clearing pass is
// needed because only entries below the peer count are read.
// When the receiver stalls, the finished word waits in the output register;
// the next packet is accepted and processed, and its word waits in the
// engine until the output register frees up.
// ----------------------------------------------------------------------------
module peer_link_loss_tracker #(
  parameter int unsigned MAX_PEERS = plt_pkg::MAX_PEERS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      ground_mode_we_i,
  input  logic      ground_mode_wdata_i,
  plt_in_if.sink    pkt_i,
  plt_out_if.source res_o
);

  logic             ground_mode_q;
  logic             out_valid_q;
  plt_pkg::result_t out_q;
  logic             res_free;
  logic             eng_valid;
  plt_pkg::result_t eng_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ground_mode_q <= 1'b0;
    end else if (ground_mode_we_i) begin
      ground_mode_q <= ground_mode_wdata_i;
    end
  end

  plt_engine #(
    .MAX_PEERS (MAX_PEERS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pkt_i         (pkt_i),
    .ground_mode_i (ground_mode_q),
    .res_free_i    (res_free),
    .res_valid_o   (eng_valid),
    .res_o         (eng_res)
  );

  assign res_free = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_valid && res_free) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_valid && res_free) begin
      out_q <= eng_res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = out_q.status;
  assign res_o.entry_idx    = out_q.entry_idx;
  assign res_o.lost_packets = out_q.lost_packets;
  assign res_o.peer_rssi    = out_q.peer_rssi;

endmodule
